@@ rtl/core/rau_pkg.sv @@
package rau_pkg;
  localparam int unsigned DEF_WIDTH = 32;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  // datapath request to the shared divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage

@@ rtl/core/rational_arithmetic_unit_top.sv @@
// sequence: after the input transfer the products are formed in S_MUL and summed in
//   S_SUM; S_GCD runs the euclid steps on the shared divider, S_QN and S_QD do the two
//   reduction divisions, and S_OUT raises the result
// zero denominator: the error result is raised from S_SUM, with no division started
// one item at a time: no new input transfer until after the result transfer; the single
//   shared restoring divider carries every division of the sequence
// products use one WIDTH by WIDTH multiplier, one product per cycle
// reset: synchronous, active high; clears the sequencer and output valid
module rational_arithmetic_unit_top import rau_pkg::*; #(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // a_num, a_den, b_num, b_den
  input  logic [1:0]   s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // res_num, res_den, then zero fill
  output logic         m_tuser    // zero_den_error
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_MUL  = 8'b00000010,
    S_SUM  = 8'b00000100,
    S_GCD  = 8'b00001000,
    S_QN   = 8'b00010000,
    S_QD   = 8'b00100000,
    S_OUT  = 8'b01000000,
    S_WAIT = 8'b10000000
  } state_t;

  state_t state;
  mode_t  mode;
  logic [WIDTH-1:0] an, ad, bn, bd;
  logic [WIDTH-1:0] p0, p1, p2;   // products
  logic [1:0]       mcnt;
  logic [WIDTH-1:0] n, d, ga, gb, qn;
  logic [WIDTH-1:0] mul_a, mul_b;
  logic [2*WIDTH-1:0] mul_full;
  logic [WIDTH-1:0] mul_r;

  div_ctl_t dctl;
  div_sts_t dsts;
  logic [WIDTH-1:0] dvd, dvs, quo, rem;

  function automatic logic [WIDTH-1:0] ext32(input logic [31:0] x);
    return WIDTH'($signed({{32{x[31]}}, x}));
  endfunction

  function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] x);
    return x[WIDTH-1] ? (~x + 1'b1) : x;
  endfunction

  // one shared multiplier, operands picked by the product count
  always_comb begin
    case (mcnt)
      2'd0:    begin mul_a = an; mul_b = (mode == MODE_MUL) ? bn : bd; end
      2'd1:    begin mul_a = ad; mul_b = (mode == MODE_DIV) ? bn : bd; end
      default: begin mul_a = ad; mul_b = bn; end
    endcase
    mul_full = mul_a * mul_b;
    mul_r    = mul_full[WIDTH-1:0];
  end

  logic [WIDTH-1:0] nres;
  logic             neg;
  always_comb begin
    neg  = (quo != '0) && (n[WIDTH-1] != d[WIDTH-1]);
    nres = neg ? (~quo + 1'b1) : quo;
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    dctl.start <= 1'b0;
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      mcnt     <= '0;
    end else begin
      case (state)
        S_IDLE: if (s_tvalid) begin
          mode  <= mode_t'(s_tuser);
          an    <= ext32(s_tdata[31:0]);
          ad    <= ext32(s_tdata[63:32]);
          bn    <= ext32(s_tdata[95:64]);
          bd    <= ext32(s_tdata[127:96]);
          mcnt  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          case (mcnt)
            2'd0:    p0 <= mul_r;
            2'd1:    p1 <= mul_r;
            default: p2 <= mul_r;
          endcase
          mcnt <= mcnt + 1'b1;
          if (mcnt == 2'd2) state <= S_SUM;
        end
        S_SUM: begin
          case (mode)
            MODE_ADD: n <= p0 + p2;
            MODE_SUB: n <= p0 - p2;
            default:  n <= p0;
          endcase
          d <= p1;
          if (p1 == '0) begin
            m_tdata  <= '0;
            m_tuser  <= 1'b1;
            m_tvalid <= 1'b1;
            state    <= S_WAIT;
          end else begin
            ga <= mag((mode == MODE_ADD) ? p0 + p2 :
                      (mode == MODE_SUB) ? p0 - p2 : p0);
            gb <= mag(p1);
            dvd <= mag((mode == MODE_ADD) ? p0 + p2 :
                       (mode == MODE_SUB) ? p0 - p2 : p0);
            dvs <= mag(p1);
            dctl.start <= 1'b1;
            state <= S_GCD;
          end
        end
        S_GCD: if (dsts.done) begin
          // euclid: a <- b, b <- a mod b
          if (rem == '0) begin
            dvd <= mag(n);
            dvs <= gb;
            ga  <= gb;
            dctl.start <= 1'b1;
            state <= S_QN;
          end else begin
            ga  <= gb;
            gb  <= rem;
            dvd <= gb;
            dvs <= rem;
            dctl.start <= 1'b1;
          end
        end
        S_QN: if (dsts.done) begin
          qn  <= nres;
          dvd <= mag(d);
          dvs <= ga;
          dctl.start <= 1'b1;
          state <= S_QD;
        end
        S_QD: if (dsts.done) state <= S_OUT;
        S_OUT: begin
          m_tdata  <= {1'b0, 31'(quo), 32'(signed'(qn))};
          m_tuser  <= 1'b0;
          m_tvalid <= 1'b1;
          state    <= S_WAIT;
        end
        S_WAIT: if (m_tready) begin
          m_tvalid <= 1'b0;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rau_divider #(.WIDTH(WIDTH)) u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .dividend(dvd), .divisor(dvs),
    .sts(dsts), .quotient(quo), .remainder(rem)
  );

  // a result is only offered while parked in the wait state
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> state == S_WAIT)
    else $error("output valid outside wait state");
  // no input taken while a result waits
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("ready while result pending");
  // divider never started while busy
  assert property (@(posedge clk) disable iff (rst) dctl.start |-> !dsts.busy)
    else $error("divider restarted while busy");
  // the error flag always comes with a zero result
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tuser) |-> m_tdata == '0)
    else $error("error result not zero");
endmodule

@@ rtl/core/rau_divider.sv @@
// restoring divider, one quotient bit per cycle
module rau_divider import rau_pkg::*; #(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  div_ctl_t         ctl,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output div_sts_t         sts,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);
  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] dsr;
  logic [WIDTH:0]   rem;
  logic [WIDTH-1:0] quo;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   shifted;

  always_comb begin
    shifted = {rem[WIDTH-1:0], quo[WIDTH-1]};
    trial   = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      dsr  <= divisor;
      rem  <= '0;
      quo  <= dividend;
      cnt  <= CW'(WIDTH);
    end else if (busy) begin
      if (trial[WIDTH]) begin
        rem <= shifted;
        quo <= {quo[WIDTH-2:0], 1'b0};
      end else begin
        rem <= trial;
        quo <= {quo[WIDTH-2:0], 1'b1};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign quotient  = quo;
  assign remainder = rem[WIDTH-1:0];
endmodule
